@@ hw/rtl/acmp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package acmp_pkg;

    localparam int PAIRS     = 64;
    localparam int WORD_W    = 64;
    localparam int PAIR_W    = $clog2(PAIRS);
    localparam int ADDR_W    = PAIR_W + 1;

    // step selector of the shared unit: which rotation follows the add
    localparam logic [1:0] STEP_ROT32 = 2'd0;
    localparam logic [1:0] STEP_ROT24 = 2'd1;
    localparam logic [1:0] STEP_ROT16 = 2'd2;
    localparam logic [1:0] STEP_ROT63 = 2'd3;

    typedef struct packed {
        logic       en;
        logic [1:0] sel;
    } gstep_ctl_t;

    // position within the 16-word group for each mix and operand slot (a, b, c, d)
    localparam logic [3:0] MIX_POS [32] = '{
        4'd0, 4'd4, 4'd8,  4'd12,
        4'd1, 4'd5, 4'd9,  4'd13,
        4'd2, 4'd6, 4'd10, 4'd14,
        4'd3, 4'd7, 4'd11, 4'd15,
        4'd0, 4'd5, 4'd10, 4'd15,
        4'd1, 4'd6, 4'd11, 4'd12,
        4'd2, 4'd7, 4'd8,  4'd13,
        4'd3, 4'd4, 4'd9,  4'd14
    };

    // word address: rounds 0..7 walk the rows, rounds 8..15 walk the columns
    function automatic logic [ADDR_W-1:0] word_addr(input logic [3:0] rnd,
                                                    input logic [2:0] mx,
                                                    input logic [1:0] slot);
        logic [3:0] j;
        j = MIX_POS[{mx, slot}];
        if (!rnd[3]) begin
            return {rnd[2:0], j};
        end
        return {j[3:1], rnd[2:0], j[0]};
    endfunction

    function automatic logic [WORD_W-1:0] rotr(input logic [WORD_W-1:0] x,
                                               input logic [1:0] sel);
        logic [WORD_W-1:0] r;
        unique case (sel)
            STEP_ROT32: r = {x[31:0], x[63:32]};
            STEP_ROT24: r = {x[23:0], x[63:24]};
            STEP_ROT16: r = {x[15:0], x[63:16]};
            STEP_ROT63: r = {x[62:0], x[63]};
            default:    r = x;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/acmp_gstep.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Shared BlaMka half step: multiply low halves, register, then add, xor and rotate.
module acmp_gstep (
    input  wire logic                   aclk,
    input  wire acmp_pkg::gstep_ctl_t   ctl,
    input  wire logic [63:0]            x_in,
    input  wire logic [63:0]            y_in,
    input  wire logic [63:0]            z_in,
    output logic [63:0]                 sum_out,
    output logic [63:0]                 mix_out
);

    logic [63:0] x_reg;
    logic [63:0] y_reg;
    logic [63:0] z_reg;
    logic [63:0] prod_reg;
    logic [1:0]  sel_reg;

    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            x_reg    <= x_in;
            y_reg    <= y_in;
            z_reg    <= z_in;
            prod_reg <= {32'd0, x_in[31:0]} * {32'd0, y_in[31:0]};
            sel_reg  <= ctl.sel;
        end
    end

    assign sum_out = x_reg + y_reg + {prod_reg[62:0], 1'b0};
    assign mix_out = acmp_pkg::rotr(z_reg ^ sum_out, sel_reg);

endmodule

`default_nettype wire

@@ hw/rtl/argon2_block_compress_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Argon2 block compression G.
// Input channel (s_): one request per word pair k of the 1 KiB block, carrying
// the reference, previous and old destination words. s_tlast marks the final
// pair; s_tuser selects xor mode (taken from the final pair for the block).
// s_tready stays high while the block is loading, so no request is stalled then.
// After the final pair the block runs the permutation on one shared BlaMka
// unit: 16 rounds of 8 mixes, each mix doing 4 word reads from the work
// banks, 4 half steps through the multiplier and 4 word writes.
// s_tready is low meanwhile and during emission.
// It then emits 64 result requests on the m_ channel, pair 0 first, m_tlast
// on pair 63; each result is read, registered and offered, and the next read
// waits until the receiver takes it. A stalled receiver holds the output
// register and freezes the block.
// Reset clears the load count, mode flag and sequencer; stores need no clear.
module argon2_block_compress_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // ref_word_lo, ref_word_hi, prev_word_lo, prev_word_hi, old_word_lo, old_word_hi
    input  wire logic [383:0] s_tdata,
    // xor_into_old
    input  wire logic [0:0]   s_tuser,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_word_lo, out_word_hi
    output logic [127:0]      m_tdata,
    output logic              m_tlast
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_PERM  = 3'd1;
    localparam logic [2:0] ST_ERD   = 3'd2;
    localparam logic [2:0] ST_EWAIT = 3'd3;
    localparam logic [2:0] ST_EOUT  = 3'd4;

    localparam logic [4:0] PH_RD_LAST = 5'd3;
    localparam logic [4:0] PH_CALC    = 5'd5;
    localparam logic [4:0] PH_WR      = 5'd13;
    localparam logic [4:0] PH_END     = 5'd16;

    localparam int PW = acmp_pkg::PAIR_W;
    localparam int AW = acmp_pkg::ADDR_W;

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] load_cnt_reg;
    logic          xor_flag_reg;
    logic [3:0]    round_reg;
    logic [2:0]    mix_reg;
    logic [4:0]    ph_reg;
    logic [PW-1:0] emit_idx_reg;
    logic [63:0]   v_reg [4];

    // word stores: work split by even/odd word, saved and old as pairs
    logic [63:0]  work_even [acmp_pkg::PAIRS];
    logic [63:0]  work_odd  [acmp_pkg::PAIRS];
    logic [127:0] saved_mem [acmp_pkg::PAIRS];
    logic [127:0] old_mem   [acmp_pkg::PAIRS];

    logic [63:0]  rd_even_reg, rd_odd_reg;
    logic         rd_sel_odd_reg;
    logic [127:0] rd_saved_reg, rd_old_reg;

    logic [127:0] out_data_reg;
    logic         out_valid_reg, out_last_reg;

    logic          s_accept;
    logic [63:0]   xl, xh;
    logic [4:0]    ph_wr_off, ph_calc_off;
    logic [1:0]    slot;
    logic [AW-1:0] waddr;
    logic [PW-1:0] rd_idx;
    logic          in_read, in_capture, in_calc, in_write;
    logic [1:0]    step;
    logic          odd_step;

    acmp_pkg::gstep_ctl_t gctl;
    logic [63:0] g_x, g_y, g_z, g_sum, g_mix;

    assign s_tready = (state_reg == ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign xl = s_tdata[63:0]    ^ s_tdata[191:128];
    assign xh = s_tdata[127:64]  ^ s_tdata[255:192];

    // phase decode of one mix
    assign ph_wr_off   = ph_reg - PH_WR;
    assign ph_calc_off = ph_reg - PH_CALC;
    assign in_read     = (state_reg == ST_PERM) && (ph_reg <= PH_RD_LAST);
    assign in_capture  = (state_reg == ST_PERM) && (ph_reg >= 5'd1) && (ph_reg <= 5'd4);
    assign in_calc     = (state_reg == ST_PERM) && (ph_reg >= PH_CALC) && (ph_reg < PH_WR);
    assign in_write    = (state_reg == ST_PERM) && (ph_reg >= PH_WR);
    assign step        = ph_calc_off[2:1];
    assign odd_step    = step[0];
    assign slot        = in_read ? ph_reg[1:0] : ph_wr_off[1:0];
    assign waddr       = acmp_pkg::word_addr(round_reg, mix_reg, slot);
    assign rd_idx      = (state_reg == ST_PERM) ? waddr[AW-1:1] : emit_idx_reg;

    // even steps update a and d, odd steps c and b
    assign g_x      = odd_step ? v_reg[2] : v_reg[0];
    assign g_y      = odd_step ? v_reg[3] : v_reg[1];
    assign g_z      = odd_step ? v_reg[1] : v_reg[3];
    assign gctl.en  = in_calc && !ph_calc_off[0];
    assign gctl.sel = step;

    acmp_gstep u_gstep (
        .aclk    (aclk),
        .ctl     (gctl),
        .x_in    (g_x),
        .y_in    (g_y),
        .z_in    (g_z),
        .sum_out (g_sum),
        .mix_out (g_mix)
    );

    // stores: write on load or on perm write-back, read registered
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            work_even[load_cnt_reg] <= xl;
            work_odd[load_cnt_reg]  <= xh;
            saved_mem[load_cnt_reg] <= {xh, xl};
            old_mem[load_cnt_reg]   <= s_tdata[383:256];
        end else if (in_write) begin
            if (waddr[0]) begin
                work_odd[waddr[AW-1:1]] <= v_reg[slot];
            end else begin
                work_even[waddr[AW-1:1]] <= v_reg[slot];
            end
        end
        rd_even_reg    <= work_even[rd_idx];
        rd_odd_reg     <= work_odd[rd_idx];
        rd_sel_odd_reg <= waddr[0];
        rd_saved_reg   <= saved_mem[emit_idx_reg];
        rd_old_reg     <= old_mem[emit_idx_reg];
    end

    // operand registers of the current mix
    always_ff @(posedge aclk) begin
        if (in_capture) begin
            v_reg[2'(ph_reg - 5'd1)] <= rd_sel_odd_reg ? rd_odd_reg : rd_even_reg;
        end else if (in_calc && ph_calc_off[0]) begin
            if (odd_step) begin
                v_reg[2] <= g_sum;
                v_reg[1] <= g_mix;
            end else begin
                v_reg[0] <= g_sum;
                v_reg[3] <= g_mix;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:  if (s_accept && s_tlast) state_next = ST_PERM;
            ST_PERM:  if (ph_reg == PH_END && mix_reg == 3'd7 && round_reg == 4'd15)
                          state_next = ST_ERD;
            ST_ERD:   state_next = ST_EWAIT;
            ST_EWAIT: state_next = ST_EOUT;
            ST_EOUT:  if (m_tready) begin
                          state_next = (emit_idx_reg == PW'(acmp_pkg::PAIRS - 1)) ?
                                       ST_LOAD : ST_ERD;
                      end
            default:  state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            load_cnt_reg  <= '0;
            xor_flag_reg  <= 1'b0;
            round_reg     <= '0;
            mix_reg       <= '0;
            ph_reg        <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                xor_flag_reg <= s_tuser[0];
                // advance the pair index, rewind on the final pair
                load_cnt_reg <= s_tlast ? '0 : load_cnt_reg + 1'b1;
                round_reg    <= '0;
                mix_reg      <= '0;
                ph_reg       <= '0;
            end
            if (state_reg == ST_PERM) begin
                if (ph_reg == PH_END) begin
                    ph_reg  <= '0;
                    mix_reg <= mix_reg + 1'b1;
                    if (mix_reg == 3'd7) begin
                        round_reg <= round_reg + 1'b1;
                    end
                end else begin
                    ph_reg <= ph_reg + 1'b1;
                end
                emit_idx_reg <= '0;
            end
            if (state_reg == ST_EWAIT) begin
                out_valid_reg <= 1'b1;
            end
            if (state_reg == ST_EOUT && m_tready) begin
                out_valid_reg <= 1'b0;
                emit_idx_reg  <= emit_idx_reg + 1'b1;
            end
        end
    end

    // output register: hold until the receiver takes it
    always_ff @(posedge aclk) begin
        if (state_reg == ST_EWAIT) begin
            out_data_reg[63:0]   <= rd_even_reg ^ rd_saved_reg[63:0] ^
                                    (xor_flag_reg ? rd_old_reg[63:0] : 64'd0);
            out_data_reg[127:64] <= rd_odd_reg ^ rd_saved_reg[127:64] ^
                                    (xor_flag_reg ? rd_old_reg[127:64] : 64'd0);
            out_last_reg         <= (emit_idx_reg == PW'(acmp_pkg::PAIRS - 1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // never load and emit at once
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("load and emit overlap");

    // the final pair starts the permutation
    a_last_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still open after final pair");

    // the final result returns the block to loading
    a_last_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not reopened after final result");

endmodule

`default_nettype wire
